// ----- rtl/core/nrmc_pkg.sv -----
// Shared types, constants and helpers of the RMC sentence parser.
// Used by every module of the block but nrmc_ram; depends on nothing else.
package nrmc_pkg;

    // Line and field geometry
    localparam int LINE_MAX   = 128;
    localparam int LINE_W     = $clog2(LINE_MAX);
    localparam int FIELD_CAP  = 10;
    localparam int NUM_FIELDS = 6;
    localparam int HDR_LEN    = 6;
    localparam int BYTE_W     = 8;
    localparam int FNUM_W     = 3;
    localparam int POS_W      = 4;
    localparam int LEN_W      = 4;

    // Comma counter saturates here
    localparam logic [FNUM_W-1:0] FC_MAX = FNUM_W'(7);

    // Field store: two banks so one line can be staged while the last one drains
    localparam int BANK_SPAN = 64;
    localparam int RAM_DEPTH = 2 * BANK_SPAN;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    // Character codes
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;

    // Accepted sentence headers, first character in the top byte
    localparam logic [HDR_LEN*BYTE_W-1:0] HDR_GP = "$GPRMC";
    localparam logic [HDR_LEN*BYTE_W-1:0] HDR_GN = "$GNRMC";

    typedef logic [LEN_W-1:0] t_len;

    // One finished sentence handed from front to back
    typedef struct packed {
        logic                       bank;
        logic [FNUM_W-1:0]          nfields;
        logic [NUM_FIELDS-1:0][LEN_W-1:0] lengths;
    } t_cmd;

    // Field store write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_ram_wr;

    // Location of character pos of field index fidx (0-based) in a bank
    function automatic logic [ADDR_W-1:0] store_addr(
        input logic              bank,
        input logic [FNUM_W-1:0] fidx,
        input logic [POS_W-1:0]  pos
    );
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(bank) << $clog2(BANK_SPAN);
        return base + ADDR_W'(fidx) * ADDR_W'(FIELD_CAP) + ADDR_W'(pos);
    endfunction

endpackage

// ----- rtl/core/nmea_rmc_sentence_parser.sv -----
// RMC sentence parser: takes one receiver byte per beat on the input and
// returns, for each newline-terminated $GPRMC/$GNRMC line, a header beat and
// then one beat per staged character of fields 1..6 (one zero-length beat per
// empty field), o_last marking the end of the run. The back end loads the
// header beat and each empty-field beat directly; for each character it
// first issues the field store address and then loads the registered read
// data, and every beat waits for a free output slot. The field store holds
// two sentences in two banks, so the input keeps flowing while the previous
// sentence drains; the input stalls only when both banks wait to be drained.
// No clearing pass follows reset. Depends on nrmc_pkg, nrmc_front, nrmc_cmd_q,
// nrmc_back and nrmc_ram.
module nmea_rmc_sentence_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [nrmc_pkg::BYTE_W-1:0]   i_byte_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [nrmc_pkg::FNUM_W-1:0]   o_field_number,
    output logic [nrmc_pkg::POS_W-1:0]    o_char_pos,
    output logic [nrmc_pkg::BYTE_W-1:0]   o_char_value,
    output logic [nrmc_pkg::LEN_W-1:0]    o_field_length,
    output logic                          o_last
);

    logic                        q_full;
    logic                        q_valid;
    logic                        push;
    logic                        pop;
    nrmc_pkg::t_cmd              cmd_in;
    nrmc_pkg::t_cmd              cmd_head;
    nrmc_pkg::t_ram_wr           ram_wr;
    logic [nrmc_pkg::ADDR_W-1:0] rd_addr;
    logic [nrmc_pkg::BYTE_W-1:0] rd_data;

    // Classify bytes and stage fields
    nrmc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_byte_value (i_byte_value),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (cmd_in),
        .o_wr         (ram_wr)
    );

    // Hold finished sentences
    nrmc_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_head  (cmd_head)
    );

    // Field store, two banks
    nrmc_ram #(
        .WIDTH (nrmc_pkg::BYTE_W),
        .DEPTH (nrmc_pkg::RAM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr.en),
        .i_wr_addr (ram_wr.addr),
        .i_wr_data (ram_wr.data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Emit result beats
    nrmc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_head         (cmd_head),
        .o_pop          (pop),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_field_number (o_field_number),
        .o_char_pos     (o_char_pos),
        .o_char_value   (o_char_value),
        .o_field_length (o_field_length),
        .o_last         (o_last)
    );

endmodule

// ----- rtl/core/nrmc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module nrmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write when enabled; read every cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/nrmc_front.sv -----
// Byte front end: tracks the line, stages fields 1..6 into the field store
// and queues a command for each matching sentence. Depends on nrmc_pkg.
module nrmc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [nrmc_pkg::BYTE_W-1:0] i_byte_value,
    input  logic                        i_q_full,
    output logic                        o_push,
    output nrmc_pkg::t_cmd              o_cmd,
    output nrmc_pkg::t_ram_wr           o_wr
);

    logic [nrmc_pkg::LINE_W-1:0]                          r_line_len, n_line_len;
    logic [nrmc_pkg::FNUM_W-1:0]                          r_fc, n_fc;
    logic [nrmc_pkg::NUM_FIELDS-1:0][nrmc_pkg::LEN_W-1:0] r_len, n_len;
    logic [nrmc_pkg::HDR_LEN-1:0][nrmc_pkg::BYTE_W-1:0]   r_hdr, n_hdr;
    logic                                                 r_bank, n_bank;

    logic                        accept;
    logic                        in_field;
    logic [nrmc_pkg::FNUM_W-1:0] fidx;
    nrmc_pkg::t_len              cur_len;
    logic                        hdr_ok;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && !i_q_full;
    assign in_field = (r_fc >= nrmc_pkg::FNUM_W'(1))
                   && (r_fc <= nrmc_pkg::FNUM_W'(nrmc_pkg::NUM_FIELDS));
    assign fidx     = r_fc - nrmc_pkg::FNUM_W'(1);
    assign cur_len  = in_field ? r_len[fidx] : '0;
    assign hdr_ok   = (r_line_len >= nrmc_pkg::LINE_W'(nrmc_pkg::HDR_LEN))
                   && ((r_hdr == nrmc_pkg::HDR_GP) || (r_hdr == nrmc_pkg::HDR_GN));

    // Command for the line that ends now
    always_comb begin
        o_cmd.bank    = r_bank;
        o_cmd.nfields = (r_fc > nrmc_pkg::FNUM_W'(nrmc_pkg::NUM_FIELDS))
                      ? nrmc_pkg::FNUM_W'(nrmc_pkg::NUM_FIELDS) : r_fc;
        o_cmd.lengths = r_len;
    end

    // Classify the byte and update the line state
    always_comb begin
        n_line_len = r_line_len;
        n_fc       = r_fc;
        n_len      = r_len;
        n_hdr      = r_hdr;
        n_bank     = r_bank;
        o_push     = 1'b0;
        o_wr.en    = 1'b0;
        o_wr.addr  = nrmc_pkg::store_addr(r_bank, fidx, cur_len);
        o_wr.data  = i_byte_value;
        if (accept) begin
            if (i_byte_value == nrmc_pkg::CHAR_CR) begin
                // ignore
            end else if (i_byte_value == nrmc_pkg::CHAR_LF) begin
                if (hdr_ok) begin
                    o_push = 1'b1;
                    n_bank = !r_bank;
                end
                n_line_len = '0;
                n_fc       = '0;
                n_len      = '0;
            end else if (r_line_len == nrmc_pkg::LINE_W'(nrmc_pkg::LINE_MAX - 1)) begin
                // drop the overlong line and this byte
                n_line_len = '0;
                n_fc       = '0;
                n_len      = '0;
            end else begin
                for (int k = 0; k < nrmc_pkg::HDR_LEN; k++) begin
                    if (r_line_len == nrmc_pkg::LINE_W'(k)) begin
                        n_hdr[nrmc_pkg::HDR_LEN-1-k] = i_byte_value;
                    end
                end
                n_line_len = r_line_len + nrmc_pkg::LINE_W'(1);
                if (i_byte_value == nrmc_pkg::CHAR_COMMA) begin
                    if (r_fc < nrmc_pkg::FC_MAX) begin
                        n_fc = r_fc + nrmc_pkg::FNUM_W'(1);
                    end
                end else if (in_field
                          && (cur_len < nrmc_pkg::LEN_W'(nrmc_pkg::FIELD_CAP))) begin
                    o_wr.en     = 1'b1;
                    n_len[fidx] = cur_len + nrmc_pkg::LEN_W'(1);
                end
            end
        end
    end

    // Line control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= '0;
            r_fc       <= '0;
            r_len      <= '0;
            r_bank     <= 1'b0;
        end else begin
            r_line_len <= n_line_len;
            r_fc       <= n_fc;
            r_len      <= n_len;
            r_bank     <= n_bank;
        end
    end

    // Header characters
    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

endmodule

// ----- rtl/core/nrmc_cmd_q.sv -----
// Two-entry command queue between front and back; one entry per store bank.
// Depends on nrmc_pkg.
module nrmc_cmd_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nrmc_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output nrmc_pkg::t_cmd o_head
);

    nrmc_pkg::t_cmd r_ent [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_head  = r_ent[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/core/nrmc_back.sv -----
// Result sequencer: walks the head command, reads staged characters from
// the field store and drives the registered output beat. Depends on nrmc_pkg.
module nrmc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  nrmc_pkg::t_cmd                i_head,
    output logic                          o_pop,
    output logic [nrmc_pkg::ADDR_W-1:0]   o_rd_addr,
    input  logic [nrmc_pkg::BYTE_W-1:0]   i_rd_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [nrmc_pkg::FNUM_W-1:0]   o_field_number,
    output logic [nrmc_pkg::POS_W-1:0]    o_char_pos,
    output logic [nrmc_pkg::BYTE_W-1:0]   o_char_value,
    output logic [nrmc_pkg::LEN_W-1:0]    o_field_length,
    output logic                          o_last
);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_ISSUE = 3'b010,
        B_LOAD  = 3'b100
    } t_bstate;

    t_bstate                     r_state, n_state;
    logic [nrmc_pkg::FNUM_W-1:0] r_fld, n_fld;
    logic [nrmc_pkg::POS_W-1:0]  r_pos, n_pos;

    logic                        r_o_valid;
    logic [nrmc_pkg::FNUM_W-1:0] r_fnum, n_fnum;
    logic [nrmc_pkg::POS_W-1:0]  r_opos, n_opos;
    logic [nrmc_pkg::BYTE_W-1:0] r_char, n_char;
    logic [nrmc_pkg::LEN_W-1:0]  r_flen, n_flen;
    logic                        r_last, n_last;

    logic                        slot_free;
    logic                        load;
    logic [nrmc_pkg::FNUM_W-1:0] fidx;
    nrmc_pkg::t_len              cur_len;
    logic                        last_fld;
    logic                        end_pos;

    assign slot_free = !r_o_valid || i_ready;
    assign fidx      = r_fld - nrmc_pkg::FNUM_W'(1);
    assign cur_len   = i_head.lengths[fidx];
    assign last_fld  = (r_fld == i_head.nfields);
    assign end_pos   = (nrmc_pkg::LEN_W'(r_pos) == cur_len - nrmc_pkg::LEN_W'(1));
    assign o_rd_addr = nrmc_pkg::store_addr(i_head.bank, fidx, r_pos);

    // Sequence header, empty-field and character beats
    always_comb begin
        n_state = r_state;
        n_fld   = r_fld;
        n_pos   = r_pos;
        o_pop   = 1'b0;
        load    = 1'b0;
        n_fnum  = r_fld;
        n_opos  = '0;
        n_char  = '0;
        n_flen  = '0;
        n_last  = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid && slot_free) begin
                    load   = 1'b1;
                    n_fnum = '0;
                    n_last = (i_head.nfields == '0);
                    if (i_head.nfields == '0) begin
                        o_pop = 1'b1;
                    end else begin
                        n_fld   = nrmc_pkg::FNUM_W'(1);
                        n_pos   = '0;
                        n_state = B_ISSUE;
                    end
                end
            end
            B_ISSUE: begin
                if (cur_len == '0) begin
                    if (slot_free) begin
                        load   = 1'b1;
                        n_last = last_fld;
                        if (last_fld) begin
                            o_pop   = 1'b1;
                            n_state = B_IDLE;
                        end else begin
                            n_fld = r_fld + nrmc_pkg::FNUM_W'(1);
                            n_pos = '0;
                        end
                    end
                end else begin
                    // read address is live this cycle; data arrives next
                    n_state = B_LOAD;
                end
            end
            B_LOAD: begin
                if (slot_free) begin
                    load   = 1'b1;
                    n_opos = r_pos;
                    n_char = i_rd_data;
                    n_flen = cur_len;
                    n_last = end_pos && last_fld;
                    if (!end_pos) begin
                        n_pos   = r_pos + nrmc_pkg::POS_W'(1);
                        n_state = B_ISSUE;
                    end else if (last_fld) begin
                        o_pop   = 1'b1;
                        n_state = B_IDLE;
                    end else begin
                        n_fld   = r_fld + nrmc_pkg::FNUM_W'(1);
                        n_pos   = '0;
                        n_state = B_ISSUE;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // Sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_fld     <= nrmc_pkg::FNUM_W'(1);
            r_pos     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fld   <= n_fld;
            r_pos   <= n_pos;
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_fnum <= n_fnum;
            r_opos <= n_opos;
            r_char <= n_char;
            r_flen <= n_flen;
            r_last <= n_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_field_number = r_fnum;
    assign o_char_pos     = r_opos;
    assign o_char_value   = r_char;
    assign o_field_length = r_flen;
    assign o_last         = r_last;

endmodule
